// ===== rtl/core/hslc_pkg.sv =====
// Shared types and constants for the HSL to RGB converter.
// Used by hslc_front, hslc_chan and hsl_to_rgb_converter_top; depends on nothing.
package hslc_pkg;

    // One color component on the 0..240 scale, or an 8-bit channel.
    typedef logic [7:0] comp_t;

    // Hue position after the per-channel offset and wrap, 0..240.
    typedef logic [7:0] hue_pos_t;

    // Ramp weight of the high intermediate, 0..40.
    typedef logic [5:0] weight_t;

    // High intermediate v2 (always non-negative) and signed v1 / v2-v1.
    typedef logic        [16:0] v2_t;
    typedef logic signed [18:0] vs_t;

    // Numerator of one channel in units of 1/(40*57600).
    typedef logic signed [25:0] num_t;
    // Clamped numerator and its value times 255 scaled down by 2048.
    typedef logic [21:0] numc_t;
    typedef logic [18:0] scaled_t;

    // Stage enables of the pipeline, one per register stage.
    typedef struct packed {
        logic en_s1;
        logic en_s2;
        logic en_s3;
        logic en_s4;
        logic en_out;
    } ctrl_t;

    localparam int unsigned NUM_CH = 3;

    localparam logic [7:0] HUE_FULL  = 8'd240;
    localparam logic [7:0] HUE_THIRD = 8'd80;
    localparam logic [7:0] L_HALF    = 8'd120;
    localparam logic [7:0] RAMP_LEN  = 8'd40;
    localparam logic [7:0] HOLD_END  = 8'd120;
    localparam logic [7:0] DOWN_END  = 8'd160;

    // Numerators at or above this value already give 256 or more.
    localparam logic [21:0] NUM_MAX = 22'd2313036;

    // 40*57600 = 2048*1125. The 2048 is a shift, the 1125 a reciprocal
    // multiply that is exact for every scaled value below 2^19.
    localparam int unsigned  PRE_SHIFT   = 11;
    localparam logic [19:0]  RECIP_MUL   = 20'd954438;
    localparam int unsigned  RECIP_SHIFT = 30;

endpackage

// ===== rtl/core/hslc_front.sv =====
// Front end of the HSL to RGB converter: the two intermediates and the
// per-channel ramp weights, in two register stages. Depends on hslc_pkg.
module hslc_front
(
    input  logic                                       clk,
    input  hslc_pkg::ctrl_t                            ctrl,
    input  hslc_pkg::comp_t                            hue,
    input  hslc_pkg::comp_t                            saturation,
    input  hslc_pkg::comp_t                            lightness,
    output hslc_pkg::vs_t                              v1,
    output hslc_pkg::vs_t                              dv,
    output hslc_pkg::weight_t [hslc_pkg::NUM_CH-1:0]   weight
);

    // Stage 1 registers.
    hslc_pkg::v2_t                                v2_reg,  v2_next;
    hslc_pkg::comp_t                              l_reg;
    hslc_pkg::hue_pos_t [hslc_pkg::NUM_CH-1:0]    t_reg,   t_next;

    // Stage 2 registers.
    hslc_pkg::vs_t                                v1_reg,  v1_next;
    hslc_pkg::vs_t                                dv_reg,  dv_next;
    hslc_pkg::weight_t  [hslc_pkg::NUM_CH-1:0]    w_reg,   w_next;

    logic [15:0] ls_prod;
    logic [17:0] l240;
    logic [17:0] sum240;
    logic [17:0] v2_wide;
    logic [8:0]  hue_red;
    logic [8:0]  lsum;
    logic [17:0] l480;

    // Stage 1: high intermediate and wrapped hue per channel.
    always_comb
    begin
        ls_prod = lightness * saturation;
        l240    = 18'(lightness) * 18'(hslc_pkg::HUE_FULL);
        lsum    = 9'(lightness) + 9'(saturation);
        sum240  = 18'(lsum) * 18'(hslc_pkg::HUE_FULL);
        if (lightness < hslc_pkg::L_HALF)
        begin
            v2_wide = l240 + 18'(ls_prod);
        end
        else
        begin
            v2_wide = sum240 - 18'(ls_prod);
        end
        v2_next = v2_wide[16:0];

        // Red is offset forward by a third of the circle.
        hue_red = 9'(hue) + 9'(hslc_pkg::HUE_THIRD);
        if (hue_red > 9'(hslc_pkg::HUE_FULL))
        begin
            t_next[0] = 8'(hue_red - 9'(hslc_pkg::HUE_FULL));
        end
        else
        begin
            t_next[0] = hue_red[7:0];
        end

        if (hue > hslc_pkg::HUE_FULL)
        begin
            t_next[1] = hue - hslc_pkg::HUE_FULL;
        end
        else
        begin
            t_next[1] = hue;
        end

        // Blue is offset back by a third; a negative position wraps once.
        if (hue < hslc_pkg::HUE_THIRD)
        begin
            t_next[2] = hue + (hslc_pkg::HUE_FULL - hslc_pkg::HUE_THIRD);
        end
        else
        begin
            t_next[2] = hue - hslc_pkg::HUE_THIRD;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en_s1)
        begin
            v2_reg <= v2_next;
            l_reg  <= lightness;
            t_reg  <= t_next;
        end
    end

    // Stage 2: low intermediate, the difference, and the band weights.
    always_comb
    begin
        l480    = 18'(l_reg) * 18'(9'd480);
        v1_next = hslc_pkg::vs_t'(19'(l480)) - hslc_pkg::vs_t'(19'(v2_reg));
        dv_next = hslc_pkg::vs_t'(19'(v2_reg)) - v1_next;
        for (int i = 0; i < hslc_pkg::NUM_CH; i++)
        begin
            if (t_reg[i] < hslc_pkg::RAMP_LEN)
            begin
                w_next[i] = t_reg[i][5:0];
            end
            else if (t_reg[i] < hslc_pkg::HOLD_END)
            begin
                w_next[i] = hslc_pkg::RAMP_LEN[5:0];
            end
            else if (t_reg[i] < hslc_pkg::DOWN_END)
            begin
                w_next[i] = 6'(hslc_pkg::DOWN_END - t_reg[i]);
            end
            else
            begin
                w_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en_s2)
        begin
            v1_reg <= v1_next;
            dv_reg <= dv_next;
            w_reg  <= w_next;
        end
    end

    assign v1     = v1_reg;
    assign dv     = dv_reg;
    assign weight = w_reg;

endmodule

// ===== rtl/core/hslc_chan.sv =====
// One output channel of the HSL to RGB converter: weighted numerator,
// clamp and scale by 255, and the exact divide by 1125. Depends on hslc_pkg.
module hslc_chan
(
    input  logic              clk,
    input  hslc_pkg::ctrl_t   ctrl,
    input  hslc_pkg::vs_t     v1,
    input  hslc_pkg::vs_t     dv,
    input  hslc_pkg::weight_t weight,
    output hslc_pkg::comp_t   color
);

    hslc_pkg::num_t    num_reg,   num_next;
    hslc_pkg::scaled_t y_reg,     y_next;
    hslc_pkg::comp_t   color_reg, color_next;

    logic signed [25:0] v1_x;
    logic signed [25:0] dv_x;
    logic signed [25:0] w_x;
    hslc_pkg::numc_t    numc;
    logic [29:0]        times255;
    logic [38:0]        prod;
    logic [8:0]         quot;

    // Stage 3: numerator = 40*v1 + (v2-v1)*weight.
    always_comb
    begin
        v1_x     = 26'(v1);
        dv_x     = 26'(dv);
        w_x      = 26'(weight);
        num_next = v1_x * 26'sd40 + dv_x * w_x;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en_s3)
        begin
            num_reg <= num_next;
        end
    end

    // Stage 4: clamp to the useful range and scale by 255/2048.
    always_comb
    begin
        if (num_reg <= 26'sd0)
        begin
            numc = '0;
        end
        else if (num_reg > hslc_pkg::num_t'(26'(hslc_pkg::NUM_MAX)))
        begin
            numc = hslc_pkg::NUM_MAX;
        end
        else
        begin
            numc = num_reg[21:0];
        end
        times255 = (30'(numc) << 8) - 30'(numc);
        y_next   = times255[29:hslc_pkg::PRE_SHIFT];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en_s4)
        begin
            y_reg <= y_next;
        end
    end

    // Stage 5: divide by 1125 through the reciprocal, saturate to 255.
    always_comb
    begin
        prod = 39'(y_reg) * 39'(hslc_pkg::RECIP_MUL);
        quot = prod[38:hslc_pkg::RECIP_SHIFT];
        if (quot[8])
        begin
            color_next = 8'hFF;
        end
        else
        begin
            color_next = quot[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en_out)
        begin
            color_reg <= color_next;
        end
    end

    assign color = color_reg;

endmodule

// ===== rtl/core/hsl_to_rgb_converter_top.sv =====
// HSL to RGB converter, top level: pipeline control and the three channels.
// Depends on hslc_pkg, hslc_front and hslc_chan.
//
// This block converts one color given as hue, saturation and lightness, each
// on a 0..240 scale (a hue of 240 is the full circle, a lightness of 120 is
// the pure color), into 8-bit red, green and blue, truncated. It accepts one
// transfer per clock cycle unless it stalls its input, and delivers each
// result through a five-stage pipeline: the high intermediate and wrapped
// hues, the low intermediate and band weights, the weighted numerator (one
// multiplier per channel), the clamp and scale by 255, and a reciprocal
// multiply that divides exactly by 1125 into the output register.
// Both channels use valid and stall; a transfer happens at a rising edge with
// valid high and stall low. A stall on the output only backs up the stages
// that hold data, so empty stages keep taking new input until the pipeline
// is full. Inputs above 240 are processed by the same formulas, with every
// channel clamped to 0..255.
module hsl_to_rgb_converter_top
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            hsl_valid,
    output logic            hsl_stall,
    input  hslc_pkg::comp_t hue,
    input  hslc_pkg::comp_t saturation,
    input  hslc_pkg::comp_t lightness,
    output logic            rgb_valid,
    input  logic            rgb_stall,
    output hslc_pkg::comp_t red,
    output hslc_pkg::comp_t green,
    output hslc_pkg::comp_t blue
);

    // Valid bits of the five register stages; the last one is the output.
    logic [4:0] vld_reg, vld_next;

    hslc_pkg::ctrl_t ctrl;

    hslc_pkg::vs_t                               v1;
    hslc_pkg::vs_t                               dv;
    hslc_pkg::weight_t [hslc_pkg::NUM_CH-1:0]    weight;
    hslc_pkg::comp_t   [hslc_pkg::NUM_CH-1:0]    color;

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb
    begin
        ctrl.en_out = !vld_reg[4] || !rgb_stall;
        ctrl.en_s4  = !vld_reg[3] || ctrl.en_out;
        ctrl.en_s3  = !vld_reg[2] || ctrl.en_s4;
        ctrl.en_s2  = !vld_reg[1] || ctrl.en_s3;
        ctrl.en_s1  = !vld_reg[0] || ctrl.en_s2;

        vld_next = vld_reg;
        if (ctrl.en_s1)
        begin
            vld_next[0] = hsl_valid;
        end
        if (ctrl.en_s2)
        begin
            vld_next[1] = vld_reg[0];
        end
        if (ctrl.en_s3)
        begin
            vld_next[2] = vld_reg[1];
        end
        if (ctrl.en_s4)
        begin
            vld_next[3] = vld_reg[2];
        end
        if (ctrl.en_out)
        begin
            vld_next[4] = vld_reg[3];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign hsl_stall = !ctrl.en_s1;
    assign rgb_valid = vld_reg[4];

    hslc_front u_front
    (
        .clk        (clk),
        .ctrl       (ctrl),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness),
        .v1         (v1),
        .dv         (dv),
        .weight     (weight)
    );

    // Channel 0 is red, 1 is green, 2 is blue.
    for (genvar c = 0; c < hslc_pkg::NUM_CH; c++)
    begin : g_chan
        hslc_chan u_chan
        (
            .clk    (clk),
            .ctrl   (ctrl),
            .v1     (v1),
            .dv     (dv),
            .weight (weight[c]),
            .color  (color[c])
        );
    end

    assign red   = color[0];
    assign green = color[1];
    assign blue  = color[2];

endmodule

// ===== test/hsl_to_rgb_converter_top_tb.sv =====
// Self-checking testbench for hsl_to_rgb_converter_top: directed and random HSL colors.
// Depends on hslc_pkg for the port types; needs nothing beyond the RTL.
module hsl_to_rgb_converter_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef hslc_pkg::comp_t comp_t;

    // One converted color as it leaves the block.
    typedef struct packed {
        comp_t red;
        comp_t green;
        comp_t blue;
    } rgb_t;

    // A row of the directed table. When has_rgb is set, the color is typed in
    // because it can be read off the conversion rules directly; otherwise the
    // expected color comes from the predictor below.
    typedef struct packed {
        comp_t hue;
        comp_t sat;
        comp_t lit;
        logic  has_rgb;
        rgb_t  rgb;
    } hsl_row_t;

    // Pacing of the two channels, changed between phases of the run.
    typedef enum logic [2:0] {
        PACE_FREE,    // no idling on either side
        PACE_SRC,     // sender idle about half the cycles
        PACE_SNK,     // receiver stalling about half the cycles
        PACE_BOTH,    // both sides idle about a quarter of the cycles
        PACE_HOLD     // receiver holds off for a long stretch, sender runs flat out
    } pace_t;

    // Color scale constants, kept signed so that negative intermediates survive.
    localparam longint SCALE_FULL = 240;
    localparam longint SCALE_THIRD = 80;
    localparam longint SCALE_HALF = 120;
    localparam longint RAMP_END = 40;
    localparam longint HOLD_END = 120;
    localparam longint FALL_END = 160;
    localparam longint UNIT_DEN = 57600;
    localparam longint LEVEL_MAX = 255;

    localparam int unsigned HOLD_CYCLES = 100;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned SETTLE_CYCLES = 10;

    localparam int unsigned NUM_ROWS = 18;

    localparam hsl_row_t HSL_ROWS [NUM_ROWS] = '{
        // Black, white and mid grey with zero saturation.
        '{8'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
        '{8'd0,   8'd0,   8'd240, 1'b1, '{8'd255, 8'd255, 8'd255}},
        '{8'd0,   8'd0,   8'd120, 1'b1, '{8'd127, 8'd127, 8'd127}},
        // Pure primaries at full saturation and half lightness.
        '{8'd0,   8'd240, 8'd120, 1'b1, '{8'd255, 8'd0,   8'd0}},
        '{8'd80,  8'd240, 8'd120, 1'b1, '{8'd0,   8'd255, 8'd0}},
        '{8'd160, 8'd240, 8'd120, 1'b1, '{8'd0,   8'd0,   8'd255}},
        // A hue of a full circle wraps back to red.
        '{8'd240, 8'd240, 8'd120, 1'b1, '{8'd255, 8'd0,   8'd0}},
        // Yellow sits on the band edges of red and green.
        '{8'd40,  8'd240, 8'd120, 1'b1, '{8'd255, 8'd255, 8'd0}},
        // Full saturation at the lightness extremes.
        '{8'd0,   8'd240, 8'd240, 1'b1, '{8'd255, 8'd255, 8'd255}},
        '{8'd0,   8'd240, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
        // Out-of-range inputs, which must clamp at both ends.
        '{8'd255, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{8'd0,   8'd255, 8'd0,   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{8'd255, 8'd0,   8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{8'd0,   8'd255, 8'd100, 1'b0, '{8'd0,   8'd0,   8'd0}},
        // Alternating bit patterns and points on the ramps.
        '{8'd170, 8'd85,  8'd170, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{8'd85,  8'd170, 8'd85,  1'b0, '{8'd0,   8'd0,   8'd0}},
        '{8'd20,  8'd240, 8'd60,  1'b0, '{8'd0,   8'd0,   8'd0}},
        '{8'd120, 8'd60,  8'd119, 1'b0, '{8'd0,   8'd0,   8'd0}}
    };

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  hsl_valid = 1'b0;
    logic  hsl_stall;
    comp_t hue = '0;
    comp_t saturation = '0;
    comp_t lightness = '0;
    logic  rgb_valid;
    logic  rgb_stall = 1'b0;
    comp_t red;
    comp_t green;
    comp_t blue;

    pace_t       pace = PACE_FREE;
    rgb_t        pending_rgb [$];
    int unsigned mismatch_count = 0;
    int unsigned hold_count = 0;
    int unsigned cycle_count = 0;

    hsl_to_rgb_converter_top i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .hsl_valid  (hsl_valid),
        .hsl_stall  (hsl_stall),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness),
        .rgb_valid  (rgb_valid),
        .rgb_stall  (rgb_stall),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    always #5 clk = ~clk;

    // Level of one channel from the low and high intermediates and the
    // channel's offset hue. The hue is wrapped once in each direction; a
    // wrapped hue of exactly a full circle stays and falls in the low band.
    function automatic comp_t channel_level(input longint lo, input longint hi,
                                            input longint pos);
        longint num;
        longint level;
        if (pos < 0)
            pos += SCALE_FULL;
        if (pos > SCALE_FULL)
            pos -= SCALE_FULL;
        if (pos < RAMP_END)
            num = lo * RAMP_END + (hi - lo) * pos;
        else if (pos < HOLD_END)
            num = hi * RAMP_END;
        else if (pos < FALL_END)
            num = lo * RAMP_END + (hi - lo) * (FALL_END - pos);
        else
            num = lo * RAMP_END;
        if (num <= 0)
            return '0;
        level = (num * LEVEL_MAX) / (RAMP_END * UNIT_DEN);
        if (level > LEVEL_MAX)
            level = LEVEL_MAX;
        return comp_t'(level);
    endfunction

    // Converts one HSL color to RGB. Both intermediates are kept in units of
    // 1/57600 so that the whole computation is exact integer math.
    function automatic rgb_t hsl_to_rgb(input comp_t h, input comp_t s, input comp_t l);
        longint hv;
        longint sv;
        longint lv;
        longint hi;
        longint lo;
        rgb_t   c;
        hv = longint'(h);
        sv = longint'(s);
        lv = longint'(l);
        if (lv < SCALE_HALF)
            hi = lv * (SCALE_FULL + sv);
        else
            hi = SCALE_FULL * (lv + sv) - lv * sv;
        lo = 2 * SCALE_FULL * lv - hi;
        c.red = channel_level(lo, hi, hv + SCALE_THIRD);
        c.green = channel_level(lo, hi, hv);
        c.blue = channel_level(lo, hi, hv - SCALE_THIRD);
        return c;
    endfunction

    // Random color component: mostly in range, with band edges and
    // out-of-range values mixed in so every bit of the field toggles.
    function automatic comp_t pick_component();
        comp_t edges [8];
        edges = '{8'd0, 8'd40, 8'd80, 8'd119, 8'd120, 8'd160, 8'd200, 8'd240};
        case ($urandom_range(9))
            0: return edges[$urandom_range(7)];
            1: return comp_t'($urandom_range(255));
            default: return comp_t'($urandom_range(240));
        endcase
    endfunction

    // Sends one color, idling first as the current pace asks. The transfer
    // completes at the first rising edge with valid high and stall low, and
    // only then is the expected color queued.
    task automatic send_color(input comp_t h, input comp_t s, input comp_t l,
                              input logic has_rgb, input rgb_t typed_rgb);
        int unsigned idle_pct;
        idle_pct = (pace == PACE_SRC) ? 50 : (pace == PACE_BOTH) ? 28 : 0;
        while ($urandom_range(99) < idle_pct)
        begin
            hsl_valid <= 1'b0;
            @(posedge clk);
        end
        hsl_valid <= 1'b1;
        hue <= h;
        saturation <= s;
        lightness <= l;
        @(posedge clk);
        while (hsl_stall)
            @(posedge clk);
        pending_rgb.push_back(has_rgb ? typed_rgb : hsl_to_rgb(h, s, l));
    endtask

    // Drops valid and waits until every queued color has come back. The
    // extra edge keeps the lowering of valid apart from the next raise.
    task automatic drain_colors();
        hsl_valid <= 1'b0;
        @(posedge clk);
        while (pending_rgb.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input pace_t next_pace, input int unsigned count);
        rgb_t unused_rgb;
        unused_rgb = '0;
        pace <= next_pace;
        for (int unsigned n = 0; n < count; n++)
            send_color(pick_component(), pick_component(), pick_component(),
                       1'b0, unused_rgb);
        drain_colors();
    endtask

    task automatic report_field(input string field, input comp_t want, input comp_t got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // Receiver: checks each completed output transfer against the oldest
    // expected color, then picks the stall for the next cycle. In the hold
    // phase it stalls for a long stretch first, so the pipeline fills up and
    // the block has to stall its input while the sender keeps offering.
    always @(posedge clk)
    begin
        rgb_t want;
        int unsigned stall_pct;
        if (rgb_valid && !rgb_stall)
        begin
            if (pending_rgb.size() == 0)
            begin
                $display("%0t: color %0d/%0d/%0d arrived with none expected",
                         $time, red, green, blue);
                mismatch_count++;
            end
            else
            begin
                want = pending_rgb.pop_front();
                report_field("red", want.red, red);
                report_field("green", want.green, green);
                report_field("blue", want.blue, blue);
            end
        end
        stall_pct = (pace == PACE_SNK) ? 50 : (pace == PACE_BOTH) ? 28 : 0;
        if (pace == PACE_HOLD && hold_count < HOLD_CYCLES)
        begin
            rgb_stall <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
        begin
            rgb_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Main sequence: reset, the directed table with no idling, then random
    // phases that change the pacing of both sides. Between phases the sender
    // pauses until every expected color has come back.
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int unsigned r = 0; r < NUM_ROWS; r++)
            send_color(HSL_ROWS[r].hue, HSL_ROWS[r].sat, HSL_ROWS[r].lit,
                       HSL_ROWS[r].has_rgb, HSL_ROWS[r].rgb);
        drain_colors();

        run_phase(PACE_FREE, 100);
        run_phase(PACE_SRC, 100);
        run_phase(PACE_SNK, 100);
        run_phase(PACE_HOLD, 50);
        run_phase(PACE_BOTH, 150);

        // The pipeline is five stages deep; a few more edges let any
        // unexpected trailing transfer show up.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
